### rtl/tcit_pkg.sv
`default_nettype none
package tcit_pkg;
    localparam int MAX_COUNTERS = 3;
    localparam int DEFAULT_COUNTER_COUNT = 3;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_PINS  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;
    localparam logic [1:0] CTRL_PORT = 2'd3;

    localparam logic [1:0] FMT_LOW  = 2'd1;
    localparam logic [1:0] FMT_HIGH = 2'd2;

    localparam logic [2:0] MODE_0 = 3'd0;
    localparam logic [2:0] MODE_1 = 3'd1;
    localparam logic [2:0] MODE_2 = 3'd2;
    localparam logic [2:0] MODE_3 = 3'd3;
    localparam logic [2:0] MODE_4 = 3'd4;
    localparam logic [2:0] MODE_5 = 3'd5;

    localparam logic [5:0] CTRL_RESET = 6'h30;
    localparam logic [7:0] READ_NONE  = 8'd255;

    // Decoded request, one per lane
    typedef struct packed {
        logic       rd;       // data port read of this lane
        logic       wr;       // data port write of this lane
        logic       ctrl;     // control word that sets mode of this lane
        logic       latch_c;  // latch count
        logic       latch_s;  // latch status
        logic       pins;
        logic       tick;
        logic       gate;
        logic [7:0] data;
    } tcit_req_t;

    function automatic logic [2:0] mode_of(input logic [5:0] cb);
        logic [2:0] m;
        m = cb[3:1];
        return m[2] & m[1] ? {1'b0, m[1:0]} : m;
    endfunction
endpackage
`default_nettype wire

### rtl/tcit_lane.sv
`default_nettype none
module tcit_lane (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire tcit_pkg::tcit_req_t req,
    output logic [7:0]             rdata,
    output logic                   out_level
);
    logic [15:0] count_reg, count_next, reload_reg, reload_next, lcount_reg, lcount_next;
    logic [5:0]  cb_reg, cb_next;
    logic [7:0]  lstat_reg, lstat_next, hold_reg, hold_next;
    logic        sl_reg, sl_next, cl_reg, cl_next, rh_reg, rh_next, wh_reg, wh_next;
    logic        gate_reg, gate_next, arm_reg, arm_next, trig_reg, trig_next;
    logic        cen_reg, cen_next, out_reg, out_next;

    always_comb begin
        logic [2:0]  m;
        logic [15:0] n, d, v, stp;
        logic        ld;
        count_next = count_reg;  reload_next = reload_reg; lcount_next = lcount_reg;
        cb_next = cb_reg;        lstat_next = lstat_reg;   hold_next = hold_reg;
        sl_next = sl_reg;        cl_next = cl_reg;         rh_next = rh_reg;
        wh_next = wh_reg;        gate_next = gate_reg;     arm_next = arm_reg;
        trig_next = trig_reg;    cen_next = cen_reg;       out_next = out_reg;
        rdata = 8'd0;
        m = tcit_pkg::mode_of(cb_reg);
        ld = 1'b0;
        v = 16'd0;
        n = count_reg;
        stp = 16'd2;
        d = cl_reg ? lcount_reg : count_reg;
        if (en) begin
            if (req.rd) begin
                if (sl_reg) begin
                    sl_next = 1'b0;
                    rdata = lstat_reg;
                end else begin
                    case (cb_reg[5:4])
                        tcit_pkg::FMT_LOW: begin
                            cl_next = 1'b0;
                            rdata = d[7:0];
                        end
                        tcit_pkg::FMT_HIGH: begin
                            cl_next = 1'b0;
                            rdata = d[15:8];
                        end
                        default: begin
                            rh_next = !rh_reg;
                            if (!rh_reg) rdata = d[7:0];
                            else begin
                                cl_next = 1'b0;
                                rdata = d[15:8];
                            end
                        end
                    endcase
                end
            end
            if (req.latch_s && !sl_reg) begin
                sl_next = 1'b1;
                lstat_next = {out_reg, 1'b0, cb_reg};
            end
            if (req.latch_c && !cl_reg) begin
                cl_next = 1'b1;
                rh_next = 1'b0;
                lcount_next = count_reg;
            end
            if (req.ctrl) begin
                cb_next = req.data[5:0];
                wh_next = 1'b0;
                rh_next = 1'b0;
                cen_next = 1'b1;
                arm_next = 1'b0;
                trig_next = 1'b0;
                out_next = tcit_pkg::mode_of(req.data[5:0]) != tcit_pkg::MODE_0;
            end
            if (req.wr) begin
                case (cb_reg[5:4])
                    tcit_pkg::FMT_LOW: begin
                        ld = 1'b1;
                        v = {reload_reg[15:8], req.data};
                    end
                    tcit_pkg::FMT_HIGH: begin
                        ld = 1'b1;
                        v = {req.data, reload_reg[7:0]};
                    end
                    default: begin
                        if (!wh_reg) begin
                            wh_next = 1'b1;
                            hold_next = req.data;
                            if (m == tcit_pkg::MODE_0) cen_next = 1'b0;
                        end else begin
                            wh_next = 1'b0;
                            cen_next = 1'b1;
                            ld = 1'b1;
                            v = {req.data, hold_reg};
                        end
                    end
                endcase
                if (ld) begin
                    reload_next = v;
                    if (m == tcit_pkg::MODE_0 || m == tcit_pkg::MODE_4) count_next = v;
                    if (!arm_reg && (m == tcit_pkg::MODE_2 || m == tcit_pkg::MODE_3))
                        count_next = v;
                    if (m == tcit_pkg::MODE_0) out_next = 1'b0;
                    arm_next = 1'b1;
                end
            end
            if (req.pins) begin
                if (req.tick) begin
                    case (m)
                        tcit_pkg::MODE_0: begin
                            if (gate_reg && cen_reg) begin
                                n = count_reg - 16'd1;
                                if (n == 16'd0 && arm_reg) begin
                                    out_next = 1'b1;
                                    arm_next = 1'b0;
                                end
                            end
                        end
                        tcit_pkg::MODE_1: begin
                            n = count_reg - 16'd1;
                            if (n == 16'd0 && trig_reg) begin
                                out_next = 1'b1;
                                trig_next = 1'b0;
                            end
                        end
                        tcit_pkg::MODE_2: begin
                            if (gate_reg && arm_reg) begin
                                if (count_reg == 16'd1) begin
                                    n = reload_reg;
                                    out_next = 1'b1;
                                end else begin
                                    n = count_reg - 16'd1;
                                    if (n == 16'd1) out_next = 1'b0;
                                end
                            end
                        end
                        tcit_pkg::MODE_3: begin
                            if (gate_reg && arm_reg) begin
                                if (count_reg[0]) stp = out_reg ? 16'd1 : 16'd3;
                                if (count_reg != 16'd0 && count_reg <= stp) begin
                                    out_next = !out_reg;
                                    n = reload_reg;
                                end else n = count_reg - stp;
                            end
                        end
                        tcit_pkg::MODE_4: begin
                            if (gate_reg) begin
                                n = count_reg - 16'd1;
                                if (arm_reg) begin
                                    if (!out_reg) begin
                                        out_next = 1'b1;
                                        arm_next = 1'b0;
                                    end else if (n == 16'd0) out_next = 1'b0;
                                end
                            end
                        end
                        default: begin
                            n = count_reg - 16'd1;
                            if (trig_reg) begin
                                if (!out_reg) begin
                                    out_next = 1'b1;
                                    trig_next = 1'b0;
                                end else if (n == 16'd0) out_next = 1'b0;
                            end
                        end
                    endcase
                    count_next = n;
                end
                if (gate_reg != req.gate) begin
                    gate_next = req.gate;
                    if (m == tcit_pkg::MODE_1 || m == tcit_pkg::MODE_5) begin
                        if (req.gate && arm_next) begin
                            count_next = reload_reg;
                            trig_next = 1'b1;
                            if (m == tcit_pkg::MODE_1) out_next = 1'b0;
                        end
                    end else if (m == tcit_pkg::MODE_2 || m == tcit_pkg::MODE_3) begin
                        if (req.gate && arm_next) count_next = reload_reg;
                        out_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg <= '0; reload_reg <= '0; lcount_reg <= '0;
            cb_reg <= tcit_pkg::CTRL_RESET; lstat_reg <= '0; hold_reg <= '0;
            sl_reg <= 1'b0; cl_reg <= 1'b0; rh_reg <= 1'b0; wh_reg <= 1'b0;
            gate_reg <= 1'b0; arm_reg <= 1'b0; trig_reg <= 1'b0;
            cen_reg <= 1'b1; out_reg <= 1'b0;
        end else begin
            count_reg <= count_next; reload_reg <= reload_next; lcount_reg <= lcount_next;
            cb_reg <= cb_next; lstat_reg <= lstat_next; hold_reg <= hold_next;
            sl_reg <= sl_next; cl_reg <= cl_next; rh_reg <= rh_next; wh_reg <= wh_next;
            gate_reg <= gate_next; arm_reg <= arm_next; trig_reg <= trig_next;
            cen_reg <= cen_next; out_reg <= out_next;
        end
    end

    assign out_level = out_next;
endmodule
`default_nettype wire

### rtl/three_channel_interval_timer_core.sv
// Channel   | Dir | Signals
// request   | in  | valid, ready, command, port, write_data, tick_mask, gate_levels
// result    | out | out_valid, out_ready, read_data, out_levels
// One request per cycle when ready; each lane updates its counter on accept and the
// merged read byte and pin levels are registered into the result stage.
// The result shows in the cycle after accept; a new request is taken whenever the
// result stage is empty or is being emptied in the same cycle.
// Reset clears all counters to their power-up state; no clearing pass.
`default_nettype none
module three_channel_interval_timer_core #(
    parameter int COUNTER_COUNT = tcit_pkg::DEFAULT_COUNTER_COUNT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       valid,
    output logic            ready,
    input  wire logic [1:0] command,
    input  wire logic [1:0] port,
    input  wire logic [7:0] write_data,
    input  wire logic [2:0] tick_mask,
    input  wire logic [2:0] gate_levels,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      read_data,
    output logic [2:0]      out_levels
);
    logic        accept;
    logic        ovalid_reg;
    logic [7:0]  rd_reg, rd_next;
    logic [2:0]  lv_reg, lv_next;
    logic [7:0]  lane_rd [COUNTER_COUNT];
    logic [COUNTER_COUNT-1:0] lane_out;

    assign ready  = !ovalid_reg || out_ready;
    assign accept = valid && ready;

    for (genvar i = 0; i < COUNTER_COUNT; i++) begin : g_lane
        tcit_pkg::tcit_req_t rq;
        always_comb begin
            rq.data    = write_data;
            rq.rd      = command == tcit_pkg::CMD_READ && port == 2'(i);
            rq.wr      = command == tcit_pkg::CMD_WRITE && port == 2'(i);
            rq.pins    = command == tcit_pkg::CMD_PINS;
            rq.tick    = tick_mask[i];
            rq.gate    = gate_levels[i];
            rq.ctrl    = 1'b0;
            rq.latch_c = 1'b0;
            rq.latch_s = 1'b0;
            if (command == tcit_pkg::CMD_WRITE && port == tcit_pkg::CTRL_PORT) begin
                if (write_data[7:6] == 2'b11) begin
                    rq.latch_s = write_data[1 + i] && !write_data[4];
                    rq.latch_c = write_data[1 + i] && !write_data[5];
                end else if (write_data[7:6] == 2'(i)) begin
                    if (write_data[5:4] == 2'b00) rq.latch_c = 1'b1;
                    else rq.ctrl = 1'b1;
                end
            end
        end
        tcit_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (accept),
            .req       (rq),
            .rdata     (lane_rd[i]),
            .out_level (lane_out[i])
        );
    end

    // Merge: pick the addressed lane's byte (255 on a read of no lane), gather pin levels
    always_comb begin
        rd_next = 8'd0;
        lv_next = 3'd0;
        if (command == tcit_pkg::CMD_READ) rd_next = tcit_pkg::READ_NONE;
        for (int i = 0; i < COUNTER_COUNT; i++) begin
            if (command == tcit_pkg::CMD_READ && port == 2'(i)) rd_next = lane_rd[i];
            lv_next[i] = lane_out[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) ovalid_reg <= 1'b0;
        else if (accept) ovalid_reg <= 1'b1;
        else if (out_ready) ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            rd_reg <= rd_next;
            lv_reg <= lv_next;
        end
    end

    assign out_valid  = ovalid_reg;
    assign read_data  = rd_reg;
    assign out_levels = lv_reg;
endmodule
`default_nettype wire
